// ===== src/ordered_process_queue_macros.svh =====
// Assertion macros used by the ordered process queue checker
`ifndef ORDERED_PROCESS_QUEUE_MACROS_SVH
`define ORDERED_PROCESS_QUEUE_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define OPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset
`define OPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/opq_pkg.sv =====
// Package with commands, status codes and the record type of the ordered process queue
`timescale 1ns / 1ps
`default_nettype none

package opq_pkg;

    // command codes
    localparam logic [2:0] CMD_ENQ  = 3'd0;
    localparam logic [2:0] CMD_DEQ  = 3'd1;
    localparam logic [2:0] CMD_INS  = 3'd2;
    localparam logic [2:0] CMD_SWAP = 3'd3;
    localparam logic [2:0] CMD_PEEK = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // one process record; {start_time, pid} is the ordering key
    typedef struct packed {
        logic [31:0] start_time;
        logic [15:0] pid;
        logic [19:0] time_slice;
        logic [19:0] job_time;
        logic [19:0] mem_size;
    } t_rec;

endpackage

`default_nettype wire

// ===== src/opq_store.sv =====
// Record memory: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module opq_store #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire opq_pkg::t_rec i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output opq_pkg::t_rec      o_rd_data
);
    import opq_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data valid the cycle after the request
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/ordered_process_queue.sv =====
// Enqueue and refused commands go straight to the done state; dequeue and peek read the head;
// sorted insert walks back from the tail, moving larger records up; swap out scans all records,
// then closes the gap by moving the records after the pick down one slot.
// One transaction at a time: a new command is taken only once the last one has left the
// sequencer; input reopens once idle, even with a result held.
// Reset (synchronous, active low) empties the queue; record memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_process_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [15:0] i_pid,
    input  wire logic [31:0] i_start_time,
    input  wire logic [19:0] i_mem_size,
    input  wire logic [19:0] i_job_time,
    input  wire logic [19:0] i_time_slice,
    input  wire logic [31:0] i_now_tick,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_pid,
    output logic [31:0]      o_out_start_time,
    output logic [19:0]      o_out_mem_size,
    output logic [19:0]      o_out_job_time,
    output logic [19:0]      o_out_time_slice,
    output logic [4:0]       o_entry_total
);
    import opq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_HEAD_RD = 8'b0000_0010,
        S_INS_RD  = 8'b0000_0100,
        S_INS_CMP = 8'b0000_1000,
        S_INS_PUT = 8'b0001_0000,
        S_SCAN    = 8'b0010_0000,
        S_SHIFT   = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx);
        f_next = (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] idx);
        f_prev = (idx == '0) ? IW'(DEPTH - 1) : idx - IW'(1);
    endfunction

    t_state        r_state, n_state;
    logic [IW-1:0] r_head, r_tail, r_pos, r_ptr, r_pend_addr;
    logic [CW-1:0] r_count, r_i, r_n;
    logic          r_pend, r_found, r_first;
    logic [31:0]   r_best, r_now;
    t_rec          r_new, r_res;
    logic [1:0]    r_status;
    logic          r_o_vld;
    logic [1:0]    r_o_status;
    t_rec          r_o_rec;
    logic [4:0]    r_o_total;

    logic          accept, is_full, is_empty, out_free;
    logic          ins_less, scan_issue, scan_qual, shift_issue;
    logic [IW-1:0] last;
    t_rec          in_rec, rd_data, wr_data;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;

    assign accept   = i_valid && !o_stall;
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign out_free = !r_o_vld || !i_stall;
    assign last     = f_prev(r_tail);

    assign in_rec = '{start_time: i_start_time, pid: i_pid, time_slice: i_time_slice,
                      job_time: i_job_time, mem_size: i_mem_size};

    // shared comparators: key order for insert, start time against tick and best for swap out
    assign ins_less    = {r_new.start_time, r_new.pid} < {rd_data.start_time, rd_data.pid};
    assign scan_qual   = (rd_data.start_time <= r_now) &&
                         (!r_found || (rd_data.start_time < r_best));
    assign scan_issue  = (r_i != r_count);
    assign shift_issue = (r_pos != last);

    opq_store #(.DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // memory port steering
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_head;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_new;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_ENQ) && !is_full) begin
                    wr_en   = 1'b1;
                    wr_addr = r_tail;
                    wr_data = in_rec;
                end
                if (accept && ((i_cmd == CMD_DEQ) || (i_cmd == CMD_PEEK)) && !is_empty) begin
                    rd_en = 1'b1;
                end
            end
            S_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = f_prev(r_pos);
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_data = ins_less ? rd_data : r_new;
            end
            S_INS_PUT: begin
                wr_en = 1'b1;
            end
            S_SCAN: begin
                rd_en   = scan_issue;
                rd_addr = r_ptr;
            end
            S_SHIFT: begin
                rd_en   = shift_issue;
                rd_addr = f_next(r_pos);
                wr_en   = r_pend;
                wr_addr = r_pend_addr;
                wr_data = rd_data;
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_ENQ:  n_state = S_DONE;
                        CMD_INS:  n_state = is_full ? S_DONE :
                                            (is_empty ? S_INS_PUT : S_INS_RD);
                        CMD_DEQ:  n_state = is_empty ? S_DONE : S_HEAD_RD;
                        CMD_PEEK: n_state = is_empty ? S_DONE : S_HEAD_RD;
                        CMD_SWAP: n_state = is_empty ? S_DONE : S_SCAN;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_HEAD_RD: n_state = S_DONE;
            S_INS_RD:  n_state = S_INS_CMP;
            S_INS_CMP: begin
                if (!ins_less) begin
                    n_state = S_DONE;
                end else if (r_n == CW'(1)) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_INS_PUT: n_state = S_DONE;
            S_SCAN: begin
                if (!scan_issue && !r_pend) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!shift_issue && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            // output register: load a finished result, drop one that was taken
            if ((r_state == S_DONE) && out_free) begin
                r_o_vld <= 1'b1;
            end else if (r_o_vld && !i_stall) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_new    <= in_rec;
                        r_now    <= i_now_tick;
                        r_res    <= '0;
                        r_n      <= r_count;
                        r_ptr    <= r_head;
                        r_i      <= '0;
                        r_found  <= 1'b0;
                        r_first  <= 1'b1;
                        r_pend   <= 1'b0;
                        case (i_cmd)
                            CMD_ENQ, CMD_INS: begin
                                r_pos <= r_tail;
                                if (is_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_tail   <= f_next(r_tail);
                                    r_count  <= r_count + CW'(1);
                                end
                            end
                            CMD_DEQ: begin
                                if (is_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_status <= ST_OK;
                                    r_head   <= f_next(r_head);
                                    r_count  <= r_count - CW'(1);
                                end
                            end
                            CMD_SWAP: begin
                                r_pos    <= r_head;
                                r_status <= is_empty ? ST_EMPTY : ST_OK;
                            end
                            CMD_PEEK: begin
                                r_status <= is_empty ? ST_EMPTY : ST_OK;
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_HEAD_RD: begin
                    r_res <= rd_data;
                end
                S_INS_CMP: begin
                    // move the larger record up one slot and keep walking back
                    if (ins_less) begin
                        r_pos <= f_prev(r_pos);
                        r_n   <= r_n - CW'(1);
                    end
                end
                S_SCAN: begin
                    if (scan_issue) begin
                        r_ptr <= f_next(r_ptr);
                        r_i   <= r_i + CW'(1);
                    end
                    r_pend      <= scan_issue;
                    r_pend_addr <= r_ptr;
                    if (r_pend) begin
                        r_first <= 1'b0;
                        if (scan_qual) begin
                            r_found <= 1'b1;
                            r_best  <= rd_data.start_time;
                            r_pos   <= r_pend_addr;
                            r_res   <= rd_data;
                        end else if (r_first) begin
                            // head is the fallback pick
                            r_res <= rd_data;
                        end
                    end
                end
                S_SHIFT: begin
                    // close the gap: read ahead one slot, write back one behind
                    if (shift_issue) begin
                        r_pos <= f_next(r_pos);
                    end
                    r_pend      <= shift_issue;
                    r_pend_addr <= r_pos;
                    if (!shift_issue && !r_pend) begin
                        r_tail  <= last;
                        r_count <= r_count - CW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_status <= r_status;
                        r_o_rec    <= r_res;
                        r_o_total  <= 5'(r_count);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_vld;
    assign o_status         = r_o_status;
    assign o_out_pid        = r_o_rec.pid;
    assign o_out_start_time = r_o_rec.start_time;
    assign o_out_mem_size   = r_o_rec.mem_size;
    assign o_out_job_time   = r_o_rec.job_time;
    assign o_out_time_slice = r_o_rec.time_slice;
    assign o_entry_total    = r_o_total;

endmodule

`default_nettype wire

// ===== src/opq_chk.sv =====
// Port-level checker for the ordered process queue and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_process_queue_macros.svh"

module opq_chk #(
    parameter int DEPTH = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_out_pid,
    input wire logic [31:0] o_out_start_time,
    input wire logic [4:0]  o_entry_total
);
    import opq_pkg::*;

    // a stalled result transaction holds
    `OPQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_pid) && $stable(o_entry_total), "result changed while stalled")

    // a refused add only happens with the queue full and carries no record
    `OPQ_ASSERT(a_full_count, i_clk, i_rst_n, o_valid && (o_status == ST_FULL) |-> (o_entry_total == 5'(DEPTH)) && (o_out_pid == 16'd0), "full status with wrong count")

    // a refused removal only happens with the queue empty and carries no record
    `OPQ_ASSERT(a_empty_count, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY) |-> (o_entry_total == 5'd0) && (o_out_start_time == 32'd0), "empty status with wrong count")

    // reset leaves no result pending and the input open
    `OPQ_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid && !o_stall, "reset did not clear control")

endmodule

bind ordered_process_queue opq_chk #(.DEPTH(DEPTH)) u_opq_chk (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the ordered process queue: random and directed commands
`timescale 1ns / 1ps

module tb_top;
    import opq_pkg::*;

    localparam int          QDEPTH         = 16;
    localparam logic [2:0]  CMD_UNDEF_LO   = 3'd5;
    localparam logic [2:0]  CMD_UNDEF_HI   = 3'd7;
    localparam int          PHASE_ITEMS    = 340;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 80;
    // worst gap: long hold-off plus one slow command, taken several times over
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SEND_IDLE_PCT[4]  = '{0, 69, 0, 18};
    localparam int          RECV_STALL_PCT[4] = '{0, 0, 69, 18};

    typedef struct packed {
        logic [2:0]  cmd;
        t_rec        rec;
        logic [31:0] now_tick;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0] status;
        t_rec       rec;
        logic [4:0] total;
    } t_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // sender side
    logic      in_valid = 1'b0;
    t_cmd_item drv_item = '0;
    logic      o_stall;

    // receiver side
    logic        rx_stall = 1'b0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_out_pid;
    logic [31:0] o_out_start_time;
    logic [19:0] o_out_mem_size;
    logic [19:0] o_out_job_time;
    logic [19:0] o_out_time_slice;
    logic [4:0]  o_entry_total;

    t_cmd_item pending_cmds[$];
    t_reply    predicted_replies[$];
    int        fail_count     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      hold_go        = 1'b0;
    logic      hold_done      = 1'b0;
    int        hold_left      = 0;
    int        idle_cycles    = 0;

    // shadow copy of the queue contents
    t_rec       shadow_slots[QDEPTH];
    logic [3:0] shadow_head = '0;
    logic [3:0] shadow_tail = '0;
    int         shadow_held = 0;

    always #1 i_clk = ~i_clk;

    ordered_process_queue #(.DEPTH(QDEPTH)) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .o_stall          (o_stall),
        .i_cmd            (drv_item.cmd),
        .i_pid            (drv_item.rec.pid),
        .i_start_time     (drv_item.rec.start_time),
        .i_mem_size       (drv_item.rec.mem_size),
        .i_job_time       (drv_item.rec.job_time),
        .i_time_slice     (drv_item.rec.time_slice),
        .i_now_tick       (drv_item.now_tick),
        .o_valid          (o_valid),
        .i_stall          (rx_stall),
        .o_status         (o_status),
        .o_out_pid        (o_out_pid),
        .o_out_start_time (o_out_start_time),
        .o_out_mem_size   (o_out_mem_size),
        .o_out_job_time   (o_out_job_time),
        .o_out_time_slice (o_out_time_slice),
        .o_entry_total    (o_entry_total)
    );

    // Apply one command to the shadow queue and return the reply it should give
    function automatic t_reply apply_to_shadow(input t_cmd_item it);
        t_reply      res;
        logic [3:0]  pos;
        logic [3:0]  ptr;
        logic [3:0]  last;
        int          n;
        int          i;
        logic        found;
        logic [31:0] best;
        res = '0;
        res.status = ST_OK;
        case (it.cmd)
            CMD_ENQ, CMD_INS: begin
                if (shadow_held >= QDEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = shadow_tail;
                    if (it.cmd == CMD_INS) begin
                        // walking back from the tail, shift up each entry while its key is above the new one
                        n = shadow_held;
                        while (n > 0 && {it.rec.start_time, it.rec.pid} <
                               {shadow_slots[pos - 4'd1].start_time,
                                shadow_slots[pos - 4'd1].pid}) begin
                            shadow_slots[pos] = shadow_slots[pos - 4'd1];
                            pos = pos - 4'd1;
                            n--;
                        end
                    end
                    shadow_slots[pos] = it.rec;
                    shadow_tail = shadow_tail + 4'd1;
                    shadow_held++;
                end
            end
            CMD_DEQ, CMD_SWAP, CMD_PEEK: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else if (it.cmd == CMD_PEEK) begin
                    res.rec = shadow_slots[shadow_head];
                end else if (it.cmd == CMD_DEQ) begin
                    res.rec = shadow_slots[shadow_head];
                    shadow_head = shadow_head + 4'd1;
                    shadow_held--;
                end else begin
                    // earliest start at or below the tick, nearest the head; else the head
                    pos = shadow_head;
                    ptr = shadow_head;
                    found = 1'b0;
                    best = '0;
                    for (i = 0; i < shadow_held; i++) begin
                        if (shadow_slots[ptr].start_time <= it.now_tick &&
                            (!found || shadow_slots[ptr].start_time < best)) begin
                            found = 1'b1;
                            best = shadow_slots[ptr].start_time;
                            pos = ptr;
                        end
                        ptr = ptr + 4'd1;
                    end
                    res.rec = shadow_slots[pos];
                    // close the gap
                    last = shadow_tail - 4'd1;
                    while (pos != last) begin
                        shadow_slots[pos] = shadow_slots[pos + 4'd1];
                        pos = pos + 4'd1;
                    end
                    shadow_tail = shadow_tail - 4'd1;
                    shadow_held--;
                end
            end
            default: ;
        endcase
        res.total = shadow_held[4:0];
        return res;
    endfunction

    function automatic t_rec random_record();
        t_rec r;
        int   mode;
        mode = $urandom_range(0, 99);
        if (mode < 40) begin
            r.start_time = $urandom_range(0, 15);
        end else if (mode < 55) begin
            r.start_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFF - 1;
        end else begin
            r.start_time = $urandom();
        end
        r.pid        = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) :
                                              16'($urandom_range(0, 16'hFFFF));
        r.mem_size   = 20'($urandom_range(0, 20'hFFFFF));
        r.job_time   = 20'($urandom_range(0, 20'hFFFFF));
        r.time_slice = 20'($urandom_range(0, 20'hFFFFF));
        return r;
    endfunction

    function automatic logic [31:0] random_tick();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 30) return $urandom_range(0, 15);
        if (mode < 45) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom();
    endfunction

    // add-heavy runs drive the queue toward full, remove-heavy runs toward empty
    function automatic t_cmd_item random_cmd(input logic fill_bias);
        t_cmd_item it;
        int        r;
        it.rec = random_record();
        it.now_tick = random_tick();
        r = $urandom_range(0, 99);
        if (r < 3) begin
            it.cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        end else if (r < (fill_bias ? 72 : 30)) begin
            it.cmd = ($urandom_range(0, 99) < 70) ? CMD_INS : CMD_ENQ;
        end else begin
            r = $urandom_range(0, 99);
            it.cmd = (r < 35) ? CMD_DEQ : (r < 80) ? CMD_SWAP : CMD_PEEK;
        end
        return it;
    endfunction

    task automatic push_cmd(input logic [2:0] cmd, input logic [31:0] start,
                            input logic [15:0] pid, input logic [31:0] tick);
        t_cmd_item it;
        it.cmd = cmd;
        it.rec = random_record();
        it.rec.start_time = start;
        it.rec.pid = pid;
        it.now_tick = tick;
        pending_cmds.push_back(it);
    endtask

    task automatic queue_random_cmds(input int count);
        t_cmd_item it;
        int        made;
        int        run_left;
        logic      fill_bias;
        made = 0;
        run_left = 0;
        fill_bias = 1'b1;
        while (made < count) begin
            if (run_left == 0) begin
                fill_bias = 1'($urandom_range(0, 1));
                run_left = $urandom_range(8, 40);
            end
            it = random_cmd(fill_bias);
            pending_cmds.push_back(it);
            // ignored commands do not count toward the total
            if (it.cmd <= CMD_PEEK) begin
                made++;
                run_left--;
            end
        end
    endtask

    // Driver: offers queued commands, predicts on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                predicted_replies.push_back(apply_to_shadow(drv_item));
            end
            if (!in_valid || !o_stall) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_item <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random back-pressure plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            rx_stall  <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            rx_stall  <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            rx_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: compares each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && !rx_stall) begin
            if (predicted_replies.size() == 0) begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end else begin
                want = predicted_replies.pop_front();
                check_field("status", want.status, o_status);
                check_field("out_pid", want.rec.pid, o_out_pid);
                check_field("out_start_time", want.rec.start_time, o_out_start_time);
                check_field("out_mem_size", want.rec.mem_size, o_out_mem_size);
                check_field("out_job_time", want.rec.job_time, o_out_job_time);
                check_field("out_time_slice", want.rec.time_slice, o_out_time_slice);
                check_field("entry_total", want.total, o_entry_total);
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !o_stall) || (o_valid && !rx_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of test
    initial begin
        t_cmd_item it;
        int        k;
        int        ph;

        // empty queue: every removal and peek refused, unknown command ignored
        push_cmd(CMD_PEEK, 32'd0, 16'd0, 32'd0);
        push_cmd(CMD_DEQ, 32'd0, 16'd0, 32'd0);
        push_cmd(CMD_SWAP, 32'd0, 16'd0, 32'hFFFF_FFFF);
        push_cmd(CMD_UNDEF_LO, 32'd0, 16'd0, 32'd0);
        // field extremes, then ordered inserts with equal start times
        it = '1;
        it.cmd = CMD_ENQ;
        pending_cmds.push_back(it);
        it = '0;
        it.cmd = CMD_INS;
        pending_cmds.push_back(it);
        push_cmd(CMD_INS, 32'd5, 16'd3, 32'd0);
        push_cmd(CMD_INS, 32'd5, 16'd2, 32'd0);
        push_cmd(CMD_INS, 32'd5, 16'd3, 32'd0);
        push_cmd(CMD_PEEK, 32'd0, 16'd0, 32'd0);
        // swap out with a qualifying record, then with none qualifying
        push_cmd(CMD_SWAP, 32'd0, 16'd0, 32'd4);
        push_cmd(CMD_SWAP, 32'd0, 16'd0, 32'd0);
        // fill to the limit, then refused adds while full
        for (k = 0; k < 13; k++) begin
            push_cmd((k % 2) ? CMD_INS : CMD_ENQ, $urandom_range(0, 15),
                     16'($urandom_range(0, 16'hFFFF)), 32'd0);
        end
        push_cmd(CMD_ENQ, 32'd1, 16'd1, 32'd0);
        push_cmd(CMD_INS, 32'd0, 16'd0, 32'd0);
        push_cmd(CMD_UNDEF_HI, 32'd0, 16'd0, 32'd0);
        push_cmd(CMD_DEQ, 32'd0, 16'd0, 32'd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random phases with different idle and stall rates
        for (ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            queue_random_cmds(PHASE_ITEMS);
            if (ph == 0) hold_go = 1'b1;
            while (pending_cmds.size() != 0) @(negedge i_clk);
        end

        while (in_valid || predicted_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && predicted_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
